// ----- hw/rtl/dctpw_pkg.sv -----
package dctpw_pkg;

	localparam int TILE_DIM      = 8;
	localparam int COORD_W       = $clog2(TILE_DIM);
	localparam int TILE_PIX      = TILE_DIM * TILE_DIM;
	localparam int IDX_W         = $clog2(TILE_PIX);
	localparam int FRAC_BITS     = 14;
	localparam int MAX_TILES_DEF = 4096;

	localparam int PIX_W      = 8;
	localparam int ML_W       = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam int BASIS_W = 15;
	localparam int MAG_W   = 14;
	localparam int P_W     = 15;
	localparam int A_W     = 29;
	localparam int B_W     = 15;
	localparam int MUL_W   = A_W + B_W;
	localparam int PROD_W  = 28;
	localparam int ACC_W   = 28;
	localparam int RND_SH  = 2 * FRAC_BITS;

	localparam int TARGET_ONE  = 5;
	localparam int TARGET_ZERO = -6;

	localparam logic [MAG_W-1:0] BASIS_DC = 14'd5793;
	localparam logic [MAG_W-1:0] COS_MAG [0:8] = '{
		14'd8192, 14'd8035, 14'd7568, 14'd6811, 14'd5793,
		14'd4551, 14'd3135, 14'd1598, 14'd0
	};

	typedef enum logic [2:0] {
		S_FILL,
		S_ACC,
		S_SUM,
		S_DEC,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_BASIS,
		PH_MUL,
		PH_EMIT
	} phase_t;

	typedef enum logic [1:0] {
		CFG_COEF_ROW,
		CFG_COEF_COL,
		CFG_EXTRACT_MODE,
		CFG_MESSAGE_LENGTH
	} cfg_idx_t;

	function automatic logic signed [BASIS_W-1:0] basis(
		input logic [COORD_W-1:0] k,
		input logic [COORD_W-1:0] i
	);
		logic [4:0]       m;
		logic [3:0]       mm;
		logic             neg;
		logic [MAG_W-1:0] mag;
		m   = 5'(7'({i, 1'b1}) * 7'(k));
		neg = 1'b0;
		if (m > 5'd24) begin
			mm = 4'(6'd32 - {1'b0, m});
		end else if (m > 5'd16) begin
			mm  = 4'(m - 5'd16);
			neg = 1'b1;
		end else if (m > 5'd8) begin
			mm  = 4'(5'd16 - m);
			neg = 1'b1;
		end else begin
			mm = 4'(m);
		end
		mag = (k == '0) ? BASIS_DC : COS_MAG[mm];
		return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

endpackage

// ----- hw/rtl/dctpw_ram.sv -----
module dctpw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/dct_parity_watermark_codec_unit.sv -----
// channel  dir  handshake              payload
// in       in   in_valid / in_stall    pixel_in, message_bit, image_start
// out      out  out_valid / out_stall  pixel_out, coef_parity, bit_valid, last_of_tile
// cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Per tile: pixels fill the tile buffer; the coefficient is accumulated on the single
// 29x15 multiplier in a basis and a multiply phase per pixel, then summed; the tile
// is decided; then each pixel is emitted via basis, multiply and emit phases.
// Reset clears sequencer, tile count, config and out_valid, but not the tile buffer.
// in_stall is high from the last pixel of a tile until the last output beat is loaded.
// out_stall holds the output register and the emit sequence.
module dct_parity_watermark_codec_unit #(
	parameter int MAX_TILES = dctpw_pkg::MAX_TILES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [dctpw_pkg::PIX_W-1:0]      pixel_in,
	input  logic                             message_bit,
	input  logic                             image_start,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [dctpw_pkg::PIX_W-1:0]      pixel_out,
	output logic                             coef_parity,
	output logic                             bit_valid,
	output logic                             last_of_tile,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dctpw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dctpw_pkg::CFG_DATA_W-1:0] cfg_data
);

	import dctpw_pkg::*;

	localparam int TC_W  = $clog2(MAX_TILES + 1);
	localparam int CMP_W = (TC_W > ML_W) ? TC_W : ML_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TILE_PIX - 1);

	state_t state_q, state_d;
	phase_t ph_q;

	logic [IDX_W-1:0]          idx_q;
	logic [COORD_W-1:0]        row_q, col_q;
	logic                      extract_q;
	logic [ML_W-1:0]           msg_len_q;
	logic [TC_W-1:0]           tile_cnt_q;
	logic                      bit_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [A_W-1:0]     d_q;
	logic                      change_q, tbit_q, tvalid_q;
	logic signed [MUL_W-1:0]   mul_q;
	logic [PIX_W-1:0]          x_q;
	logic                      out_valid_q, xbit_out_q, bvalid_out_q, last_out_q;
	logic [PIX_W-1:0]          pix_out_q;

	logic                      in_acc, out_load;
	logic [IDX_W-1:0]          eff_pos;
	logic                      ram_we;
	logic [IDX_W-1:0]          ram_addr;
	logic [PIX_W-1:0]          ram_rdata;
	logic signed [BASIS_W-1:0] bu, bv;
	logic signed [A_W-1:0]     mul_a;
	logic signed [B_W-1:0]     mul_b;
	logic signed [MUL_W-1:0]   mul_res;
	logic [PROD_W-1:0]         pm;
	logic [MAG_W-1:0]          p_mag;
	logic signed [P_W-1:0]     p_val;
	logic [ACC_W-1:0]          acc_mag;
	logic [ACC_W:0]            acc_rnd;
	logic                      parity;
	logic [CMP_W-1:0]          lim;
	logic                      tile_valid, tile_change;
	logic signed [A_W-1:0]     tgt;
	logic signed [MUL_W-RND_SH-1:0] q_fl;
	logic [RND_SH-1:0]         rem;
	logic                      rnd_up;
	logic signed [MUL_W-RND_SH:0]   pix_sum;
	logic [PIX_W-1:0]          pix_sat, pix_new;

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && !in_stall;
	assign eff_pos   = image_start ? '0 : idx_q;

	dctpw_ram #(
		.WIDTH(PIX_W),
		.DEPTH(TILE_PIX)
	) u_tile_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(pixel_in),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_FILL: if (in_acc && eff_pos == LAST_IDX) state_d = S_ACC;
			S_ACC:  if (ph_q == PH_MUL && idx_q == LAST_IDX) state_d = S_SUM;
			S_SUM:  state_d = S_DEC;
			S_DEC:  state_d = S_OUT;
			S_OUT:  if (out_load && idx_q == LAST_IDX) state_d = S_FILL;
			default: state_d = S_FILL;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		ram_we   = 1'b0;
		ram_addr = idx_q;
		out_load = 1'b0;
		mul_a    = A_W'(bu);
		mul_b    = bv;
		case (state_q)
			S_FILL: begin
				in_stall = 1'b0;
				ram_we   = in_valid;
				ram_addr = eff_pos;
			end
			S_ACC: begin
				if (ph_q == PH_MUL) begin
					mul_a = A_W'($signed({1'b0, ram_rdata}));
					mul_b = p_val;
				end
			end
			S_OUT: begin
				if (ph_q == PH_MUL) begin
					mul_a = d_q;
					mul_b = p_val;
				end
				out_load = (ph_q == PH_EMIT) && (!out_valid_q || !out_stall);
			end
			default: ;
		endcase
	end

	assign bu      = basis(row_q, idx_q[IDX_W-1:COORD_W]);
	assign bv      = basis(col_q, idx_q[COORD_W-1:0]);
	assign mul_res = mul_a * mul_b;

	assign pm    = mul_q[MUL_W-1] ? PROD_W'(-mul_q) : PROD_W'(mul_q);
	assign p_mag = MAG_W'((pm + PROD_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
	assign p_val = mul_q[MUL_W-1] ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});

	assign acc_mag    = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign acc_rnd    = {1'b0, acc_mag} + (ACC_W + 1)'(1 << (FRAC_BITS - 1));
	assign parity     = acc_rnd[FRAC_BITS];
	assign lim        = (CMP_W'(msg_len_q) < CMP_W'(MAX_TILES)) ? CMP_W'(msg_len_q)
	                                                           : CMP_W'(MAX_TILES);
	assign tile_valid  = CMP_W'(tile_cnt_q) < lim;
	assign tile_change = tile_valid && !extract_q && (parity != bit_q);
	assign tgt = bit_q ? A_W'(TARGET_ONE * (2 ** FRAC_BITS))
	                   : A_W'(TARGET_ZERO * (2 ** FRAC_BITS));

	assign q_fl    = mul_q[MUL_W-1:RND_SH];
	assign rem     = mul_q[RND_SH-1:0];
	assign rnd_up  = (rem > (RND_SH'(1) << (RND_SH - 1)))
	              || (rem == (RND_SH'(1) << (RND_SH - 1)) && q_fl[0]);
	assign pix_sum = $signed({{(MUL_W - RND_SH + 1 - PIX_W){1'b0}}, x_q})
	               + (MUL_W - RND_SH + 1)'(q_fl)
	               + $signed({{(MUL_W - RND_SH){1'b0}}, rnd_up});
	assign pix_sat = pix_sum[MUL_W-RND_SH] ? '0
	               : (pix_sum > (MUL_W - RND_SH + 1)'(255)) ? '1 : PIX_W'(pix_sum);
	assign pix_new = change_q ? pix_sat : x_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= COORD_W'(4);
			col_q     <= COORD_W'(1);
			extract_q <= 1'b0;
			msg_len_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_COEF_ROW:       row_q     <= cfg_data[COORD_W-1:0];
				CFG_COEF_COL:       col_q     <= cfg_data[COORD_W-1:0];
				CFG_EXTRACT_MODE:   extract_q <= cfg_data[0];
				CFG_MESSAGE_LENGTH: msg_len_q <= cfg_data[ML_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FILL;
			ph_q        <= PH_BASIS;
			idx_q       <= '0;
			tile_cnt_q  <= '0;
			bit_q       <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_FILL: begin
					if (in_acc) begin
						if (image_start) begin
							tile_cnt_q <= '0;
						end
						if (eff_pos == '0) begin
							bit_q <= message_bit;
						end
						idx_q <= (eff_pos == LAST_IDX) ? '0 : eff_pos + 1'b1;
						ph_q  <= PH_BASIS;
						acc_q <= '0;
					end
				end
				S_ACC: begin
					if (ph_q == PH_BASIS) begin
						if (idx_q != '0) begin
							acc_q <= acc_q + ACC_W'(mul_q);
						end
						ph_q <= PH_MUL;
					end else begin
						ph_q <= PH_BASIS;
						if (idx_q != LAST_IDX) begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_SUM: begin
					acc_q <= acc_q + ACC_W'(mul_q);
				end
				S_DEC: begin
					if (tile_cnt_q < TC_W'(MAX_TILES)) begin
						tile_cnt_q <= tile_cnt_q + 1'b1;
					end
					idx_q <= '0;
					ph_q  <= PH_BASIS;
				end
				S_OUT: begin
					case (ph_q)
						PH_BASIS: ph_q <= PH_MUL;
						PH_MUL:   ph_q <= PH_EMIT;
						PH_EMIT: begin
							if (out_load) begin
								ph_q  <= PH_BASIS;
								idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
							end
						end
						default: ph_q <= PH_BASIS;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_ACC || state_q == S_OUT) begin
			if (ph_q == PH_BASIS || ph_q == PH_MUL) begin
				mul_q <= mul_res;
			end
		end
		if (state_q == S_OUT && ph_q == PH_MUL) begin
			x_q <= ram_rdata;
		end
		if (state_q == S_DEC) begin
			d_q      <= tgt - A_W'(acc_q);
			change_q <= tile_change;
			tbit_q   <= tile_valid && extract_q && parity;
			tvalid_q <= tile_valid;
		end
		if (out_load) begin
			pix_out_q    <= pix_new;
			xbit_out_q   <= tbit_q;
			bvalid_out_q <= tvalid_q;
			last_out_q   <= (idx_q == LAST_IDX);
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_out     = pix_out_q;
	assign coef_parity   = xbit_out_q;
	assign bit_valid     = bvalid_out_q;
	assign last_of_tile  = last_out_q;

`ifndef NO_ASSERTIONS
	a_tile_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && eff_pos == LAST_IDX) |=> (state_q == S_ACC && in_stall))
		else $error("tile not handed to the accumulate pass");

	a_emit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && ph_q == PH_EMIT && out_valid_q && out_stall)
		|=> ($stable(idx_q) && ph_q == PH_EMIT))
		else $error("emit sequence advanced under stall");

	a_passthrough: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && !change_q) |=> (pixel_out == $past(x_q)))
		else $error("unchanged tile altered a pixel");

	a_bit_within_msg: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !bit_valid) |-> !coef_parity)
		else $error("bit reported outside message");
`endif

endmodule
